FILE: rtl/lip_pkg.sv
package lip_pkg;

    localparam int DATA_W  = 32;
    localparam int BASIS_FRAC = 24;
    localparam int ORD_W   = 4;
    localparam int CNT_W   = 9;

    // Table depth; the index field and the count register are sized for it.
    localparam int MAX_POINTS = 256;
    localparam int PTR_W      = $clog2(MAX_POINTS);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_X0,
        ST_RD_X1,
        ST_CDIV,
        ST_RD_XJ,
        ST_RD_XM,
        ST_BDIV,
        ST_BMUL,
        ST_RD_YJ,
        ST_TMUL,
        ST_DONE
    } t_state;

    // Divider handshake between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = v;
            if (v > 64'sd2147483647) r = 64'sd2147483647;
            else if (v < -64'sd2147483648) r = -64'sd2147483648;
            return r;
        end
    endfunction

endpackage

FILE: rtl/lip_div.sv
// Signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
module lip_div
    import lip_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        shifted = {r_rem, r_quo[63]};
        trial   = shifted - {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd0;
            n_rem  = 64'd0;
            n_quo  = i_req.num[63] ? (~i_req.num + 64'd1) : i_req.num;
            n_den  = i_req.den[63] ? (~i_req.den + 64'd1) : i_req.den;
            n_neg  = i_req.num[63] ^ i_req.den[63];
        end else if (r_busy) begin
            if (!trial[64]) begin
                n_rem = trial[63:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = shifted[63:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_neg) n_quo = ~n_quo + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: rtl/lip_table.sv
// Point table: two synchronous memories, one write and one read port each.
module lip_table
    import lip_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [PTR_W-1:0]  i_waddr,
    input  logic [DATA_W-1:0] i_wx,
    input  logic [DATA_W-1:0] i_wy,
    input  logic [PTR_W-1:0]  i_raddr,
    output logic [DATA_W-1:0] o_rx,
    output logic [DATA_W-1:0] o_ry
);

    logic [DATA_W-1:0] mem_x [MAX_POINTS];
    logic [DATA_W-1:0] mem_y [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_x[i_waddr] <= i_wx;
            mem_y[i_waddr] <= i_wy;
        end
        o_rx <= mem_x[i_raddr];
        o_ry <= mem_y[i_raddr];
    end

endmodule

FILE: rtl/lagrange_interp_1d_stencil.sv
// Channel   | Direction | tdata fields (low to high)                         | tuser
// s_axis    | in        | point_index[7:0] point_x[39:8] point_y[71:40]      | req_type
//           |           | query_x[103:72], zero pad to 104 bits              |
// m_axis    | out       | interp_value[31:0], zero pad to 32 bits            | div_fault
// cfg       | in        | index 0 stencil_order, index 1 point_count         |
// A load beat is taken and the next beat can follow at once. A query's result waits on
// the shared 64-step divider, which serves the centre division and each basis division.
// A zero spacing ends a query early. Reset is synchronous and clears control
// only; the table is undefined until loaded. A stalled result holds in the output
// register and blocks the next beat.
module lagrange_interp_1d_stencil
    import lip_pkg::*;
#(
    parameter int MAX_ORDER  = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // point_index, point_x, point_y, query_x
    input  logic         s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // interp_value
    output logic         m_axis_tuser,  // div_fault
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [8:0]   i_cfg_data
);

    localparam int AW = PTR_W;

    t_state r_state, n_state;
    logic [ORD_W-1:0] r_order;
    logic [CNT_W-1:0] r_count;
    logic signed [31:0] r_x, r_x0, r_xj;
    logic signed [63:0] r_basis, r_sum, r_prod;
    logic [AW-1:0] r_first;
    logic [ORD_W:0] r_j, r_m, r_ord;
    logic r_fault;
    logic r_ovalid;
    logic [31:0] r_odata;
    logic r_ofault;
    logic [AW-1:0] raddr;
    logic [31:0] rx, ry;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // effective count and order
    logic [CNT_W-1:0] cnt_eff;
    logic [ORD_W:0] ord_eff;
    always_comb begin
        cnt_eff = r_count;
        if (r_count > CNT_W'(MAX_POINTS)) cnt_eff = CNT_W'(MAX_POINTS);
        if (r_count == '0) cnt_eff = CNT_W'(1);
        ord_eff = {1'b0, r_order};
        if (ord_eff > (ORD_W+1)'(MAX_ORDER)) ord_eff = (ORD_W+1)'(MAX_ORDER);
        ord_eff[0] = 1'b0;
        if ({{(CNT_W-ORD_W-1){1'b0}}, ord_eff} > cnt_eff - CNT_W'(1))
            ord_eff = (ORD_W+1)'((cnt_eff - CNT_W'(1)) & ~CNT_W'(1));
    end

    logic load_acc, query_acc;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign load_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD);
    assign query_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_QUERY);

    lip_table u_table (
        .i_clk  (i_clk),
        .i_we   (load_acc && ({24'd0, s_axis_tdata[7:0]} < 32'(MAX_POINTS))),
        .i_waddr(AW'(s_axis_tdata[7:0])),
        .i_wx   (s_axis_tdata[39:8]),
        .i_wy   (s_axis_tdata[71:40]),
        .i_raddr(raddr),
        .o_rx   (rx),
        .o_ry   (ry)
    );

    lip_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic signed [63:0] dx, qv, lo, hi;
    logic [AW-1:0] idx_j, idx_m, first_c;
    assign dx = 64'(signed'(rx)) - 64'(r_x0);
    assign qv = signed'(div_rsp.quo);
    assign lo = 64'(ord_eff >> 1);
    assign hi = 64'(cnt_eff) - 64'd1 - lo;
    assign idx_j = r_first + AW'(r_j);
    assign idx_m = r_first + AW'(r_m);

    // Clamped first stencil entry from the centre quotient.
    always_comb begin
        if (qv < lo) first_c = '0;
        else if (qv > hi) first_c = AW'(hi - lo);
        else first_c = AW'(qv - lo);
    end

    // The read address selects the entry that the next state consumes.
    always_comb begin
        case (r_state)
            ST_IDLE:  raddr = '0;
            ST_RD_X0: raddr = AW'(MAX_POINTS > 1 ? 1 : 0);
            ST_CDIV:  raddr = first_c;
            ST_RD_XJ: raddr = r_first;
            ST_BMUL:  raddr = (r_m == r_ord) ? idx_j : idx_m + AW'(1);
            ST_TMUL:  raddr = idx_j + AW'(1);
            default:  raddr = idx_m;
        endcase
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = 64'd0;
        div_req.den   = 64'd0;
        case (r_state)
            ST_RD_X1: begin
                div_req.start = (dx != 0);
                div_req.num   = 64'(r_x) - 64'(r_x0);
                div_req.den   = dx;
            end
            ST_RD_XM: begin
                div_req.start = (r_m != r_j) && (r_xj != signed'(rx));
                div_req.num   = (64'(r_x) - 64'(signed'(rx))) <<< BASIS_FRAC;
                div_req.den   = 64'(r_xj) - 64'(signed'(rx));
            end
            default: ;
        endcase
    end

    logic signed [63:0] bround, tround, rsat;
    assign rsat   = sat32(qv);
    assign bround = sat32((r_prod + 64'sd8388608) >>> BASIS_FRAC);
    assign tround = (r_prod + 64'sd8388608) >>> BASIS_FRAC;

    // One shared 32 by 32 multiplier; basis and factors are saturated to 32 bits.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    assign mul_a = signed'(r_basis[31:0]);
    assign mul_b = (r_state == ST_RD_YJ) ? signed'(ry) : signed'(rsat[31:0]);
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (query_acc) n_state = ST_RD_X0;
            ST_RD_X0: n_state = ST_RD_X1;
            ST_RD_X1: n_state = (dx == 0) ? ST_DONE : ST_CDIV;
            ST_CDIV:  if (div_rsp.done) n_state = ST_RD_XJ;
            ST_RD_XJ: n_state = ST_RD_XM;
            ST_RD_XM: begin
                if (r_m == r_j) n_state = ST_BMUL;
                else if (r_xj == signed'(rx)) n_state = ST_DONE;
                else n_state = ST_BDIV;
            end
            ST_BDIV:  if (div_rsp.done) n_state = ST_BMUL;
            ST_BMUL:  n_state = (r_m == r_ord) ? ST_RD_YJ : ST_RD_XM;
            ST_RD_YJ: n_state = ST_TMUL;
            ST_TMUL:  n_state = (r_j == r_ord) ? ST_DONE : ST_RD_XJ;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_order  <= ORD_W'(2);
            r_count  <= CNT_W'(256);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == CFG_ORDER) r_order <= i_cfg_data[ORD_W-1:0];
            if (i_cfg_we && i_cfg_index == CFG_COUNT) r_count <= i_cfg_data;
            if (r_state == ST_DONE) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                r_x <= signed'(s_axis_tdata[103:72]);
                r_fault <= 1'b0;
                r_sum <= 64'sd0;
                r_ord <= ord_eff;
            end
            ST_RD_X0: r_x0 <= signed'(rx);
            ST_RD_X1: if (dx == 0) r_fault <= 1'b1;
            ST_CDIV: if (div_rsp.done) begin
                r_first <= first_c;
                r_j <= '0;
                r_m <= '0;
            end
            ST_RD_XJ: begin
                r_xj <= signed'(rx);
                r_basis <= 64'sd16777216;
                r_m <= '0;
            end
            ST_RD_XM: begin
                if (r_m == r_j) r_prod <= r_basis <<< BASIS_FRAC;
                else if (r_xj == signed'(rx)) r_fault <= 1'b1;
            end
            ST_BDIV: if (div_rsp.done) r_prod <= mul_p;
            ST_BMUL: begin
                r_basis <= (r_m == r_j) ? r_basis : bround;
                r_m <= r_m + (ORD_W+1)'(1);
            end
            ST_RD_YJ: r_prod <= mul_p;
            ST_TMUL: begin
                r_sum <= r_sum + tround;
                r_j <= r_j + (ORD_W+1)'(1);
            end
            ST_DONE: begin
                r_odata  <= r_fault ? 32'd0 : 32'(sat32(r_sum));
                r_ofault <= r_fault;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ofault;

endmodule

FILE: rtl/lip_checker.sv
module lip_checker
    import lip_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic m_axis_tuser
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A fault beat carries a zero value.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("fault with nonzero value");

    // No input is taken while a result waits.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // Result never appears the cycle after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");

endmodule

bind lagrange_interp_1d_stencil lip_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

FILE: tb/tb_lagrange_interp_1d_stencil.sv
module tb_lagrange_interp_1d_stencil;
    import lip_pkg::*;

    localparam int  GRID_STEP   = 65536;
    localparam int  HOLD_CYCLES = 3000;
    localparam int  SETTLE      = 12;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam longint Q_ONE    = 64'sd1 <<< BASIS_FRAC;
    localparam longint Q_HALF   = 64'sd1 <<< (BASIS_FRAC - 1);

    typedef struct packed {
        logic [31:0] value;
        logic        fault;
    } t_interp;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;  // point_index, point_x, point_y, query_x
    logic         s_axis_tuser = 1'b0;  // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;  // interp_value
    logic         m_axis_tuser;  // div_fault
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = 1'b0;
    logic [8:0]   i_cfg_data = '0;

    lagrange_interp_1d_stencil DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    logic signed [31:0] tab_x [256];
    logic signed [31:0] tab_y [256];
    logic [ORD_W-1:0]   cur_order = 4'd2;
    logic [CNT_W-1:0]   cur_count = 9'd256;
    t_interp            pending_interp [$];
    int                 mismatches = 0;
    longint             cycles = 0;
    bit                 tx_steady = 0;
    bit                 rx_steady = 0;
    bit                 hold_req = 0;
    int                 hold_left = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random backpressure or, in steady phases, always ready, with a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 17);
        end
    end

    always @(posedge i_clk) begin
        t_interp exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_interp.size() == 0) begin
                $error("unexpected result beat: interp_value %h div_fault %b",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                exp_r = pending_interp.pop_front();
                if (m_axis_tdata !== exp_r.value) begin
                    $error("interp_value: expected %h, actual %h", exp_r.value, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== exp_r.fault) begin
                    $error("div_fault: expected %b, actual %b", exp_r.fault, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    function automatic longint clamp_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint eff_count();
        longint c;
        c = cur_count;
        if (c > 256) c = 256;
        if (c < 1) c = 1;
        return c;
    endfunction

    function automatic t_interp interpolate(logic signed [31:0] qx);
        longint cnt, ord, half, x, x0, dx, q, xj, den, num, r, bas, sum;
        int     first, j, m;
        bit     fault;
        t_interp res;
        fault = 0;
        sum = 0;
        cnt = eff_count();
        ord = cur_order;
        if (ord > 8) ord = 8;
        ord = ord & ~64'sd1;
        if (ord > cnt - 1) ord = (cnt - 1) & ~64'sd1;
        half = ord / 2;
        x = qx;
        x0 = tab_x[0];
        dx = longint'(tab_x[1]) - x0;
        if (dx == 0) begin
            fault = 1;
        end else begin
            q = (x - x0) / dx;
            if (q < half) q = half;
            if (q > cnt - 1 - half) q = cnt - 1 - half;
            first = int'(q - half);
            for (j = 0; j <= ord && !fault; j++) begin
                xj = tab_x[first + j];
                bas = Q_ONE;
                for (m = 0; m <= ord && !fault; m++) begin
                    if (m != j) begin
                        den = xj - longint'(tab_x[first + m]);
                        if (den == 0) begin
                            fault = 1;
                        end else begin
                            num = x - longint'(tab_x[first + m]);
                            r = clamp_q((num * Q_ONE) / den);
                            bas = clamp_q((bas * r + Q_HALF) >>> BASIS_FRAC);
                        end
                    end
                end
                if (!fault)
                    sum += (longint'(tab_y[first + j]) * bas + Q_HALF) >>> BASIS_FRAC;
            end
        end
        res.fault = fault;
        res.value = fault ? 32'd0 : 32'(clamp_q(sum));
        return res;
    endfunction

    task automatic send_item(logic req, logic [7:0] idx, logic [31:0] px,
                             logic [31:0] py, logic [31:0] qx);
        while (!tx_steady && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {qx, py, px, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (req == REQ_LOAD) begin
            tab_x[idx] = px;
            tab_y[idx] = py;
        end else begin
            pending_interp.push_back(interpolate(qx));
        end
    endtask

    task automatic load_point(int idx, logic [31:0] px, logic [31:0] py);
        send_item(REQ_LOAD, idx[7:0], px, py, $urandom);
    endtask

    task automatic query_at(logic [31:0] qx);
        send_item(REQ_QUERY, 8'($urandom), $urandom, $urandom, qx);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_interp.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ORDER) cur_order = val[ORD_W-1:0];
        else cur_count = val;
    endtask

    function automatic logic [31:0] grid_x(int idx);
        return (idx - 128) * GRID_STEP + int'($urandom_range(16000)) - 8000;
    endfunction

    function automatic logic [31:0] rand_y();
        if ($urandom_range(99) < 70) return int'($urandom_range(2097152)) - 1048576;
        return $urandom;
    endfunction

    task automatic test_fill_table();
        for (int i = 0; i < 256; i++) load_point(i, grid_x(i), rand_y());
    endtask

    task automatic test_directed();
        logic [31:0] keep0, keep1;
        query_at(32'h8000_0000);
        query_at(32'h7fff_ffff);
        query_at(tab_x[0]);
        query_at(tab_x[128] + 1234);
        load_point(255, grid_x(255), 32'h7fff_ffff);
        load_point(254, grid_x(254), 32'h7fff_ffff);
        load_point(253, grid_x(253), 32'h8000_0000);
        query_at(tab_x[254]);
        query_at(tab_x[255] + 5 * GRID_STEP);
        keep0 = tab_x[0];
        keep1 = tab_x[1];
        load_point(0, 32'h8000_0000, 32'h8000_0000);
        query_at(32'h0000_0000);
        load_point(0, 32'h7fff_ffff, 32'hffff_ffff);
        query_at(32'h8000_0000);
        // Equal first abscissae make the spacing zero.
        load_point(1, tab_x[0], 32'h0);
        query_at(32'h1234_5678);
        load_point(0, keep0, rand_y());
        load_point(1, keep1, rand_y());
        // A repeated abscissa inside the stencil gives a zero denominator.
        load_point(101, tab_x[100], rand_y());
        query_at(tab_x[100]);
        load_point(101, grid_x(101), rand_y());
        query_at(tab_x[101]);
        drain();
    endtask

    task automatic run_phase(int order, int count, int n_items, int query_pct);
        int cnt;
        write_reg(CFG_ORDER, order[8:0]);
        write_reg(CFG_COUNT, count[8:0]);
        cnt = int'(eff_count());
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < query_pct) begin
                if ($urandom_range(99) < 85)
                    query_at(tab_x[0] + int'($urandom_range((cnt + 4) * GRID_STEP))
                             - 2 * GRID_STEP);
                else
                    query_at($urandom);
            end else begin
                int idx;
                idx = $urandom_range(255);
                if ($urandom_range(99) < 80) load_point(idx, grid_x(idx), rand_y());
                else load_point(idx, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int k = 0; k < 6; k++) query_at(tab_x[0] + int'($urandom_range(250 * GRID_STEP)));
        drain();
    endtask

    task automatic test_random();
        run_phase(2, 256, 350, 40);
        tx_steady = 1;
        rx_steady = 1;
        run_phase(0, 1, 150, 60);
        tx_steady = 0;
        rx_steady = 0;
        run_phase(8, 256, 40, 35);
        run_phase(4, 20, 150, 40);
        run_phase(15, 9, 30, 35);
        run_phase(6, 400, 60, 30);
        run_phase(2, 0, 120, 45);
        run_phase(3, 2, 100, 45);
        run_phase(2, 256, 150, 40);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_table();
        test_directed();
        test_backpressure();
        test_random();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_interp.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
